// File: rtl/sle_pkg.sv
// Shared types and constants for the sorted list engine.
package sle_pkg;

   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_type;

endpackage

// File: rtl/sle_datapath.sv
// Datapath: request registers, sorted cell row, fill count and result registers.
module sle_datapath #(
   parameter int CAPACITY   = sle_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = sle_pkg::DEF_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sle_pkg::ctl_type                    ctl,
   input  logic [sle_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [sle_pkg::VALUE_W-1:0]  req_new_value,
   input  logic [sle_pkg::POS_W-1:0]           req_position,
   output logic signed [sle_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic [sle_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sle_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                rsp_is_empty_flag
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > sle_pkg::POS_W) ? CNT_W : sle_pkg::POS_W;
   localparam int POS_SPAN = 2 ** sle_pkg::POS_W;
   localparam int WIN = (CAPACITY < POS_SPAN) ? CAPACITY : POS_SPAN;

   sle_pkg::cmd_type              cmd_ff;
   logic signed [DATA_WIDTH-1:0]  value_ff;
   logic [sle_pkg::POS_W-1:0]     pos_ff;

   logic signed [DATA_WIDTH-1:0]  entries_ff [CAPACITY];
   logic signed [DATA_WIDTH-1:0]  entries_in [CAPACITY];
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;

   logic signed [sle_pkg::VALUE_W-1:0]  value_out_ff;
   sle_pkg::status_type                 status_ff;
   logic [sle_pkg::COUNT_W-1:0]         count_out_ff;
   logic                                empty_ff;

   logic [CAPACITY-1:0]           stay;
   logic signed [DATA_WIDTH-1:0]  read_val;
   logic signed [DATA_WIDTH-1:0]  value_out;
   sle_pkg::status_type           status;
   logic                          in_range;

   // capture the request word
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= sle_pkg::cmd_type'(req_cmd);
         value_ff <= DATA_WIDTH'(req_new_value);
         pos_ff   <= req_position;
      end
   end

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      value_out  = '0;
      status     = sle_pkg::STAT_OK;
      read_val   = '0;

      // each cell holds its place when valid and larger than the new value
      for (int i = 0; i < CAPACITY; i++) begin
         stay[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] > value_ff);
      end

      for (int i = 0; i < WIN; i++) begin
         if (pos_ff == sle_pkg::POS_W'(i)) begin
            read_val = entries_ff[i];
         end
      end

      in_range = CMP_W'(pos_ff) < CMP_W'(count_ff);

      unique case (cmd_ff)
         sle_pkg::CMD_INSERT: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               status = sle_pkg::STAT_FULL;
            end else begin
               if (!stay[0]) begin
                  entries_in[0] = value_ff;
               end
               for (int i = 1; i < CAPACITY; i++) begin
                  if (!stay[i]) begin
                     entries_in[i] = stay[i-1] ? value_ff : entries_ff[i-1];
                  end
               end
               count_in = CNT_W'(count_ff + 1'b1);
            end
         end
         sle_pkg::CMD_READ: begin
            if (in_range) begin
               value_out = read_val;
            end else begin
               status = sle_pkg::STAT_RANGE;
            end
         end
         sle_pkg::CMD_REMOVE: begin
            if (in_range) begin
               value_out = read_val;
               // close the gap: every cell at or past the position, but the last, takes its successor
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (CMP_W'(i) >= CMP_W'(pos_ff)) begin
                     entries_in[i] = entries_ff[i+1];
                  end
               end
               count_in = CNT_W'(count_ff - 1'b1);
            end else begin
               status = sle_pkg::STAT_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         entries_ff <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         value_out_ff <= sle_pkg::VALUE_W'(value_out);
         status_ff    <= status;
         count_out_ff <= sle_pkg::COUNT_W'(count_in);
         empty_ff     <= (count_in == '0);
      end
   end

   assign rsp_entry_value   = value_out_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_out_ff;
   assign rsp_is_empty_flag = empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.execute |=> $stable(count_ff))
      else $error("fill count moved without an executed command");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (ctl.execute && cmd_ff == sle_pkg::CMD_INSERT && count_ff != CNT_W'(CAPACITY))
      |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not grow the list by one");

endmodule

// File: rtl/sle_controller.sv
// Controller: sequences capture, execute and response handoff.
module sle_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sle_pkg::ctl_type  ctl
);

   sle_pkg::state_type state_ff;
   sle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sle_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ctl.capture = 1'b0;
      ctl.execute = 1'b0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = sle_pkg::S_EXEC;
            end
         end
         sle_pkg::S_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = sle_pkg::S_RESP;
         end
         sle_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = sle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/sorted_list_indexed_engine.sv
// Top level of the sorted list engine: controller plus datapath.
//
// Keeps up to CAPACITY signed values in descending order (position 0 is the
// largest). Each request word carries a command: insert (placed ahead of
// equal values), read at position, or remove at position.
// Request channel req_*: a word is taken on a rising edge with req_valid high
// and req_stall low. Response channel rsp_*: one word per request, taken on a
// rising edge with rsp_valid high and rsp_stall low.
// After a request is taken the controller moves through its execute state,
// where the cell row and the response word are registered, and then raises rsp_valid.
// A new request is not taken until the response to the previous one has been
// taken, as the controller steps through its capture / execute / respond
// sequence; the whole cell row shifts in the execute state.
// While rsp_stall is high the response word holds and req_stall stays high.
// Reset (synchronous, active high) empties the list and returns the
// controller to idle; stored values are not cleared, since only entries
// below the fill count are ever read.
module sorted_list_indexed_engine #(
   parameter int CAPACITY   = sle_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = sle_pkg::DEF_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sle_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [sle_pkg::VALUE_W-1:0]  req_new_value,
   input  logic [sle_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sle_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic [sle_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sle_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                rsp_is_empty_flag
);

   // command strobes from the controller to the datapath
   sle_pkg::ctl_type ctl;

   sle_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // cell row, fill count and the registered response word
   sle_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .req_cmd           (req_cmd),
      .req_new_value     (req_new_value),
      .req_position      (req_position),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty_flag (rsp_is_empty_flag)
   );

endmodule
